// ----- rtl/gft_pkg.sv -----
// shared types and constants of the gait foot trajectory block
package gft_pkg;

   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 24;
   localparam int unsigned GAIN_W       = 24;
   localparam int unsigned Q16_W        = 16;
   localparam int unsigned TRAVEL_W     = 16;
   localparam int unsigned S_W          = 24;
   localparam int unsigned ALONG_W      = S_W + 2;
   localparam int unsigned PROD_W       = TRAVEL_W + ALONG_W;
   localparam int unsigned SINE_W       = 17;
   localparam int unsigned OFFSET_CODE_W = 3;
   localparam int unsigned OFFSET_FIELDS = 6;

   localparam logic [17:0] LEG_OFFSETS_RESET = 18'd99864;
   localparam logic [15:0] DUTY_RESET        = 16'd32768;
   localparam logic [23:0] GAIN_RESET        = 24'd131072;
   localparam logic [15:0] LIFT_RESET        = 16'd0;
   localparam logic [S_W-1:0] S_HALF         = S_W'(32768);
   localparam logic [S_W-1:0] S_ONE          = S_W'(65536);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEG_OFFSETS = 3'd0,
      CSR_DUTY        = 3'd1,
      CSR_STANCE_GAIN = 3'd2,
      CSR_SWING_GAIN  = 3'd3,
      CSR_LIFT_HEIGHT = 3'd4
   } csr_index_type;

endpackage

// ----- rtl/gft_scale.sv -----
// rounds a travel times along product to nearest, halves away from zero, and saturates
module gft_scale (
   input  logic signed [gft_pkg::PROD_W-1:0] prod,
   output logic signed [15:0]                value
);
   import gft_pkg::*;

   logic              neg;
   logic [PROD_W-1:0] mag;
   logic [PROD_W-1:0] rnd_sum;
   logic [PROD_W-17:0] rnd;

   always_comb begin
      neg     = prod[PROD_W-1];
      mag     = neg ? PROD_W'(-prod) : PROD_W'(prod);
      rnd_sum = mag + PROD_W'(32768);
      rnd     = rnd_sum[PROD_W-1:16];
      if (neg) begin
         if (rnd > (PROD_W-16)'(32768)) begin
            value = -16'sd32768;
         end else begin
            value = 16'(-rnd);
         end
      end else begin
         if (rnd > (PROD_W-16)'(32767)) begin
            value = 16'sd32767;
         end else begin
            value = 16'(rnd);
         end
      end
   end

endmodule

// ----- rtl/gait_foot_trajectory.sv -----
// top level of the gait foot trajectory pipeline
// throughput: one item per cycle; the six register stages advance together and
// hold while a finished result is stalled at the output register
// reset: synchronous, clears the stage valid bits and loads the register defaults
module gait_foot_trajectory #(
   parameter int unsigned LEG_COUNT        = 6,
   parameter int unsigned SINE_TABLE_DEPTH = 256,
   parameter int unsigned PHASE_BITS       = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_en,
   input  logic [gft_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gft_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [2:0]                        req_leg_index,
   input  logic [15:0]                       req_cycle_phase,
   input  logic signed [15:0]                req_travel_x,
   input  logic signed [15:0]                req_travel_y,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [15:0]                rsp_offset_x,
   output logic signed [15:0]                rsp_offset_y,
   output logic [15:0]                       rsp_lift,
   output logic                              rsp_in_swing
);
   import gft_pkg::*;

   localparam int unsigned PW    = PHASE_BITS;
   localparam int unsigned UP    = (PHASE_BITS > 16) ? PHASE_BITS - 16 : 0;
   localparam int unsigned DOWN  = (PHASE_BITS < 16) ? 16 - PHASE_BITS : 0;
   localparam int unsigned IDX_W = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
   localparam int unsigned MUL_W = PW + GAIN_W;
   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   function automatic logic [SINE_W-1:0] sine_entry(input int unsigned i);
      logic [63:0] j;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      j = 64'(i);
      if (2 * j > 64'(SINE_TABLE_DEPTH)) begin
         j = 64'(SINE_TABLE_DEPTH) - j;
      end
      x    = (PI_Q30 * j) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) begin
            sum = (sum > term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      if (sum > (64'd1 << 30)) begin
         sum = 64'd1 << 30;
      end
      return SINE_W'((sum * 64'd65536 + (64'd1 << 29)) >> 30);
   endfunction

   // constant tables
   logic [SINE_W-1:0] sine_rom [SINE_TABLE_DEPTH];
   logic [PW-1:0]     offset_tab [8];

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_sine
      localparam logic [SINE_W-1:0] SINE_VAL = sine_entry(g);
      assign sine_rom[g] = SINE_VAL;
   end

   for (genvar g = 0; g < 8; g++) begin : g_offset
      localparam logic [63:0] OFF_FULL = (64'(g) * (64'd1 << PHASE_BITS) + 64'd3) / 64'd6;
      assign offset_tab[g] = OFF_FULL[PW-1:0];
   end

   // configuration registers
   logic [17:0]       leg_offsets_ff;
   logic [15:0]       duty_ff;
   logic [GAIN_W-1:0] stance_gain_ff;
   logic [GAIN_W-1:0] swing_gain_ff;
   logic [15:0]       lift_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         leg_offsets_ff <= LEG_OFFSETS_RESET;
         duty_ff        <= DUTY_RESET;
         stance_gain_ff <= GAIN_RESET;
         swing_gain_ff  <= GAIN_RESET;
         lift_height_ff <= LIFT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LEG_OFFSETS: leg_offsets_ff <= csr_wdata[17:0];
            CSR_DUTY:        duty_ff        <= csr_wdata[15:0];
            CSR_STANCE_GAIN: stance_gain_ff <= csr_wdata[GAIN_W-1:0];
            CSR_SWING_GAIN:  swing_gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_LIFT_HEIGHT: lift_height_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   logic [PW-1:0] duty_p;
   assign duty_p = PW'(({24'd0, duty_ff} << UP) >> DOWN);

   // pipeline control
   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // stage 1: leg offset and phase wrap
   logic [OFFSET_CODE_W-1:0] code;
   logic [PW-1:0]            phase_p;
   logic [PW-1:0]            p_in, p1_ff;
   logic signed [15:0]       tx1_ff, ty1_ff;

   always_comb begin
      code = '0;
      if (4'(req_leg_index) < 4'(LEG_COUNT) && 4'(req_leg_index) < 4'(OFFSET_FIELDS)) begin
         code = OFFSET_CODE_W'(leg_offsets_ff >> (5'(req_leg_index) * 5'd3));
      end
      phase_p = PW'(({24'd0, req_cycle_phase} << UP) >> DOWN);
      p_in    = phase_p + offset_tab[code];
   end

   // stage 2: stance or swing, operand and gain select
   logic              swing_in, swing2_ff;
   logic [PW-1:0]     m_in, m2_ff;
   logic [GAIN_W-1:0] gain_in, gain2_ff;
   logic signed [15:0] tx2_ff, ty2_ff;

   always_comb begin
      swing_in = !(p1_ff < duty_p);
      m_in     = swing_in ? p1_ff - duty_p : p1_ff;
      gain_in  = swing_in ? swing_gain_ff : stance_gain_ff;
   end

   // stage 3: position inside the part of the cycle
   logic [MUL_W-1:0]   prod_in, prod3_ff;
   logic               swing3_ff;
   logic signed [15:0] tx3_ff, ty3_ff;

   assign prod_in = MUL_W'(m2_ff) * MUL_W'(gain2_ff);

   // stage 4: along and sine index
   logic [S_W-1:0]            s3;
   logic signed [ALONG_W-1:0] along_in, along4_ff;
   logic                      lift_on_in, lift_on4_ff;
   logic [31:0]               idx_prod;
   logic [IDX_W-1:0]          idx_in, idx4_ff;
   logic                      swing4_ff;
   logic signed [15:0]        tx4_ff, ty4_ff;

   always_comb begin
      s3         = S_W'(prod3_ff >> PW);
      along_in   = swing3_ff ? ALONG_W'($signed({2'b00, s3}) - $signed({2'b00, S_HALF}))
                             : ALONG_W'($signed({2'b00, S_HALF}) - $signed({2'b00, s3}));
      lift_on_in = swing3_ff && (s3 < S_ONE);
      idx_prod   = 32'(s3[15:0]) * 32'(SINE_TABLE_DEPTH);
      idx_in     = IDX_W'(idx_prod >> 16);
   end

   // stage 5: sine read and travel products
   logic [SINE_W-1:0]        sine_in, sine5_ff;
   logic signed [PROD_W-1:0] px_in, py_in, px5_ff, py5_ff;
   logic                     swing5_ff;

   always_comb begin
      sine_in = lift_on4_ff ? sine_rom[idx4_ff] : '0;
      px_in   = PROD_W'(tx4_ff) * PROD_W'(along4_ff);
      py_in   = PROD_W'(ty4_ff) * PROD_W'(along4_ff);
   end

   // stage 6: rounding, saturation and lift scaling
   logic [33:0]        lift_mul;
   logic [15:0]        lift_in;
   logic signed [15:0] ox_in, oy_in;
   logic signed [15:0] rsp_offset_x_ff, rsp_offset_y_ff;
   logic [15:0]        rsp_lift_ff;
   logic               rsp_in_swing_ff;

   always_comb begin
      lift_mul = 34'(lift_height_ff) * 34'(sine5_ff) + 34'd32768;
      lift_in  = lift_mul[31:16];
   end

   gft_scale u_scale_x (
      .prod  (px5_ff),
      .value (ox_in)
   );

   gft_scale u_scale_y (
      .prod  (py5_ff),
      .value (oy_in)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         p1_ff           <= p_in;
         tx1_ff          <= req_travel_x;
         ty1_ff          <= req_travel_y;
         swing2_ff       <= swing_in;
         m2_ff           <= m_in;
         gain2_ff        <= gain_in;
         tx2_ff          <= tx1_ff;
         ty2_ff          <= ty1_ff;
         prod3_ff        <= prod_in;
         swing3_ff       <= swing2_ff;
         tx3_ff          <= tx2_ff;
         ty3_ff          <= ty2_ff;
         along4_ff       <= along_in;
         lift_on4_ff     <= lift_on_in;
         idx4_ff         <= idx_in;
         swing4_ff       <= swing3_ff;
         tx4_ff          <= tx3_ff;
         ty4_ff          <= ty3_ff;
         sine5_ff        <= sine_in;
         px5_ff          <= px_in;
         py5_ff          <= py_in;
         swing5_ff       <= swing4_ff;
         rsp_offset_x_ff <= ox_in;
         rsp_offset_y_ff <= oy_in;
         rsp_lift_ff     <= lift_in;
         rsp_in_swing_ff <= swing5_ff;
      end
   end

   assign rsp_offset_x = rsp_offset_x_ff;
   assign rsp_offset_y = rsp_offset_y_ff;
   assign rsp_lift     = rsp_lift_ff;
   assign rsp_in_swing = rsp_in_swing_ff;

endmodule

// ----- bench/tb_top.sv -----
// testbench of the gait foot trajectory block: directed corners, random gaits, back pressure
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gft_pkg::*;

   localparam int unsigned LEGS         = 6;
   localparam int unsigned SINE_DEPTH   = 256;
   localparam int unsigned PHASE_W      = 16;
   localparam int unsigned PIPE_LATENCY = 6;
   localparam int unsigned IDLE_PCT     = 28;
   localparam int unsigned HOLD_CYCLES  = 300;
   localparam int unsigned QUIET_LIMIT  = 3000;
   localparam int unsigned MAX_REPORTS  = 40;
   localparam longint unsigned PI_Q30   = 64'd3373259426;
   localparam longint unsigned GAIN_MAX = 64'hFF_FFFF;
   localparam longint unsigned PHASE_MASK = (64'd1 << PHASE_W) - 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_FIRST = 3'd5;

   typedef struct packed {
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic [15:0]        lift;
      logic               in_swing;
   } foot_sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_leg_index = '0;
   logic [15:0] req_cycle_phase = '0;
   logic signed [15:0] req_travel_x = '0;
   logic signed [15:0] req_travel_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_offset_x;
   logic signed [15:0] rsp_offset_y;
   logic [15:0] rsp_lift;
   logic rsp_in_swing;

   logic rsp_hold = 1'b0;
   bit steady = 1'b0;
   int mismatch_count = 0;
   int quiet_cycles = 0;

   logic [16:0] sine_q16 [SINE_DEPTH];
   foot_sample_type pending_feet[$];

   logic [17:0] cfg_leg_offsets = LEG_OFFSETS_RESET;
   logic [15:0] cfg_duty        = DUTY_RESET;
   logic [23:0] cfg_stance_gain = GAIN_RESET;
   logic [23:0] cfg_swing_gain  = GAIN_RESET;
   logic [15:0] cfg_lift_height = LIFT_RESET;

   gait_foot_trajectory #(
      .LEG_COUNT       (LEGS),
      .SINE_TABLE_DEPTH(SINE_DEPTH),
      .PHASE_BITS      (PHASE_W)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_leg_index  (req_leg_index),
      .req_cycle_phase(req_cycle_phase),
      .req_travel_x   (req_travel_x),
      .req_travel_y   (req_travel_y),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_offset_x   (rsp_offset_x),
      .rsp_offset_y   (rsp_offset_y),
      .rsp_lift       (rsp_lift),
      .rsp_in_swing   (rsp_in_swing)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // sin(pi * i / depth) in Q16 from a Q30 series
   function automatic logic [16:0] half_sine_q16(input int unsigned i);
      longint unsigned j, x, x2, term, sum;
      int k;
      j = i;
      if (2 * j > SINE_DEPTH) j = SINE_DEPTH - j;
      x = (PI_Q30 * j) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) sum = (sum > term) ? sum - term : 64'd0;
         else sum = sum + term;
      end
      if (sum > (64'd1 << 30)) sum = 64'd1 << 30;
      return 17'((sum * 64'd65536 + (64'd1 << 29)) >> 30);
   endfunction

   function automatic logic signed [15:0] scaled_offset(input logic signed [15:0] travel,
                                                        input longint along);
      longint prod, r;
      longint unsigned mag;
      prod = longint'(travel) * along;
      mag = (prod < 0) ? unsigned'(-prod) : unsigned'(prod);
      r = longint'((mag + 64'd32768) >> 16);
      if (prod < 0) r = -r;
      if (r > 32767) r = 32767;
      if (r < -32768) r = -32768;
      return r[15:0];
   endfunction

   function automatic foot_sample_type predict_foot(input logic [2:0] leg,
                                                    input logic [15:0] phase,
                                                    input logic signed [15:0] tx,
                                                    input logic signed [15:0] ty);
      foot_sample_type f;
      longint unsigned code, off, p, s, idx, lift;
      longint along;
      code = 0;
      lift = 0;
      if (leg < LEGS && leg < OFFSET_FIELDS) code = (cfg_leg_offsets >> (3 * leg)) & 64'd7;
      off = ((code << PHASE_W) + 64'd3) / 64'd6;
      p = (64'(phase) + off) & PHASE_MASK;
      f.in_swing = (p >= 64'(cfg_duty));
      if (!f.in_swing) begin
         s = (p * 64'(cfg_stance_gain)) >> PHASE_W;
         along = 32768 - longint'(s);
      end else begin
         s = ((p - 64'(cfg_duty)) * 64'(cfg_swing_gain)) >> PHASE_W;
         along = longint'(s) - 32768;
         if (s < 64'd65536) begin
            idx = (s * SINE_DEPTH) >> 16;
            if (idx >= SINE_DEPTH) idx = SINE_DEPTH - 1;
            lift = (64'(cfg_lift_height) * 64'(sine_q16[idx]) + 64'd32768) >> 16;
            if (lift > 64'hFFFF) lift = 64'hFFFF;
         end
      end
      f.offset_x = scaled_offset(tx, along);
      f.offset_y = scaled_offset(ty, along);
      f.lift = lift[15:0];
      return f;
   endfunction

   function automatic logic signed [15:0] pick_travel();
      case ($urandom_range(15))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (index)
         CSR_LEG_OFFSETS: cfg_leg_offsets = value[17:0];
         CSR_DUTY:        cfg_duty = value[15:0];
         CSR_STANCE_GAIN: cfg_stance_gain = value[23:0];
         CSR_SWING_GAIN:  cfg_swing_gain = value[23:0];
         CSR_LIFT_HEIGHT: cfg_lift_height = value[15:0];
         default: ;
      endcase
   endtask

   task automatic set_gait(input logic [15:0] duty_q16, input logic [15:0] height,
                           input logic [17:0] offsets);
      longint unsigned stance_g, swing_g;
      stance_g = (duty_q16 == 0) ? GAIN_MAX :
                 ((64'd1 << 32) + 64'(duty_q16) / 2) / 64'(duty_q16);
      swing_g = ((64'd1 << 32) + (64'd65536 - duty_q16) / 2) / (64'd65536 - duty_q16);
      if (stance_g > GAIN_MAX) stance_g = GAIN_MAX;
      if (swing_g > GAIN_MAX) swing_g = GAIN_MAX;
      write_csr(CSR_LEG_OFFSETS, 24'(offsets));
      write_csr(CSR_DUTY, 24'(duty_q16));
      write_csr(CSR_STANCE_GAIN, stance_g[23:0]);
      write_csr(CSR_SWING_GAIN, swing_g[23:0]);
      write_csr(CSR_LIFT_HEIGHT, 24'(height));
   endtask

   task automatic send_foot_request(input logic [2:0] leg, input logic [15:0] phase,
                                    input logic signed [15:0] tx,
                                    input logic signed [15:0] ty);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_leg_index <= leg;
      req_cycle_phase <= phase;
      req_travel_x <= tx;
      req_travel_y <= ty;
      do @(posedge clock); while (req_stall !== 1'b0);
      pending_feet.push_back(predict_foot(leg, phase, tx, ty));
   endtask

   task automatic send_random_feet(input int count);
      int n;
      for (n = 0; n < count; n++)
         send_foot_request(3'($urandom_range(7)), 16'($urandom), pick_travel(),
                           pick_travel());
   endtask

   task automatic finish_burst;
      req_valid <= 1'b0;
      while (pending_feet.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic test_reset_defaults;
      send_random_feet(12);
      finish_burst();
   endtask

   task automatic test_directed_corners;
      int leg_no;
      // leg codes 0, 6, 7, 1, 5, 3
      write_csr(CSR_LEG_OFFSETS, 24'd119792);
      write_csr(CSR_DUTY, 24'd32768);
      write_csr(CSR_STANCE_GAIN, 24'd131072);
      write_csr(CSR_SWING_GAIN, 24'd131072);
      write_csr(CSR_LIFT_HEIGHT, 24'hFFFF);
      for (leg_no = 0; leg_no < 8; leg_no++)
         send_foot_request(3'(leg_no), 16'd0, 16'sh8000, 16'sh7FFF);
      send_foot_request(3'd0, 16'hFFFF, 16'sh7FFF, 16'sh8000);
      send_foot_request(3'd0, 16'd32767, 16'sd1000, -16'sd1000);
      send_foot_request(3'd0, 16'd32768, -16'sd1000, 16'sd1000);
      send_foot_request(3'd0, 16'd49152, 16'sh5555, -16'sh5555);
      finish_burst();

      // zero duty: always swing
      write_csr(CSR_DUTY, 24'd0);
      write_csr(CSR_SWING_GAIN, 24'd65536);
      send_foot_request(3'd0, 16'd0, 16'sh7FFF, 16'sh8000);
      send_foot_request(3'd5, 16'hFFFF, 16'sh8000, 16'sh7FFF);
      finish_burst();

      // gains far too large for the duty
      write_csr(CSR_DUTY, 24'hFFFF);
      write_csr(CSR_STANCE_GAIN, 24'hFFFFFF);
      write_csr(CSR_SWING_GAIN, 24'hFFFFFF);
      send_foot_request(3'd0, 16'd0, 16'sh7FFF, 16'sh8000);
      send_foot_request(3'd0, 16'd30000, 16'sh7FFF, 16'sh8000);
      send_foot_request(3'd0, 16'hFFFF, 16'sh8000, 16'sh7FFF);
      send_foot_request(3'd7, 16'hFFFF, 16'sd1, -16'sd1);
      finish_burst();

      // swing running past the end of the lift
      write_csr(CSR_DUTY, 24'd16384);
      send_foot_request(3'd0, 16'd1000, 16'sh7FFF, 16'sh8000);
      send_foot_request(3'd0, 16'd60000, 16'sh8000, 16'sh7FFF);
      send_foot_request(3'd0, 16'd16384, 16'sd12345, -16'sd12345);
      finish_burst();
   endtask

   task automatic test_csr_masking;
      int spare;
      set_gait(16'd40000, 16'd20000, 18'd0);
      write_csr(CSR_LEG_OFFSETS, 24'hFFFFFF);
      write_csr(CSR_DUTY, 24'hAB8000);
      write_csr(CSR_LIFT_HEIGHT, 24'hFF1234);
      for (spare = CSR_SPARE_FIRST; spare < (1 << CSR_INDEX_W); spare++)
         write_csr(CSR_INDEX_W'(spare), CSR_DATA_W'($urandom));
      send_random_feet(12);
      finish_burst();
   endtask

   task automatic test_random_gaits;
      int round_no;
      logic [15:0] duty_q16, height;
      logic [17:0] offsets;
      for (round_no = 0; round_no < 8; round_no++) begin
         duty_q16 = 16'($urandom);
         height = 16'($urandom);
         offsets = 18'($urandom);
         case (round_no)
            0: duty_q16 = 16'd1;
            1: duty_q16 = 16'hFFFF;
            2: duty_q16 = 16'd0;
            3: height = 16'hFFFF;
            4: offsets = 18'h3FFFF;
            6: height = 16'd0;
            default: ;
         endcase
         set_gait(duty_q16, height, offsets);
         if (round_no == 5) begin
            write_csr(CSR_STANCE_GAIN, CSR_DATA_W'($urandom));
            write_csr(CSR_SWING_GAIN, CSR_DATA_W'($urandom));
         end
         send_random_feet(190);
         finish_burst();
      end
   endtask

   task automatic test_back_pressure;
      set_gait(16'($urandom), 16'($urandom), 18'($urandom));
      steady = 1'b1;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_random_feet(90);
      join
      steady = 1'b0;
      finish_burst();
   endtask

   task automatic test_steady_stream;
      set_gait(16'($urandom), 16'($urandom), 18'($urandom));
      steady = 1'b1;
      send_random_feet(250);
      steady = 1'b0;
      finish_burst();
   endtask

   task automatic report_mismatch(input string field, input longint want_v, input longint got_v);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("%0t: %s expected %0d got %0d", $time, field, want_v, got_v);
   endtask

   always @(posedge clock) begin : rsp_checker
      foot_sample_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (pending_feet.size() == 0) begin
            report_mismatch("unexpected item, offset_x", 0, rsp_offset_x);
         end else begin
            want = pending_feet.pop_front();
            if (rsp_offset_x !== want.offset_x)
               report_mismatch("offset_x", want.offset_x, rsp_offset_x);
            if (rsp_offset_y !== want.offset_y)
               report_mismatch("offset_y", want.offset_y, rsp_offset_y);
            if (rsp_lift !== want.lift)
               report_mismatch("lift", want.lift, rsp_lift);
            if (rsp_in_swing !== want.in_swing)
               report_mismatch("in_swing", want.in_swing, rsp_in_swing);
         end
      end
      rsp_stall <= rsp_hold || (!steady && $urandom_range(99) < IDLE_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < SINE_DEPTH; i++) sine_q16[i] = half_sine_q16(i);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_corners();
      test_csr_masking();
      test_random_gaits();
      test_back_pressure();
      test_steady_stream();
      if (pending_feet.size() != 0)
         report_mismatch("items never returned", 0, pending_feet.size());
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/gft_pkg.sv
rtl/gft_scale.sv
rtl/gait_foot_trajectory.sv
bench/tb_top.sv
